>>> rtl/core/gnpa_pkg.sv
package gnpa_pkg;

   // Fixed field widths
   localparam int SLOT_W   = 10;
   localparam int CFG_W    = 10;
   localparam int STATUS_W = 2;

   // Defaults for the pool
   localparam int POOL_NODES_DEFAULT = 1024;
   localparam int INIT_SEGMENT_RESET = 3;

   // Request codes
   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EXHAUSTED = 2'd1,
      STATUS_OUTSIDE   = 2'd2
   } status_type;

endpackage

>>> rtl/core/gnpa_req_if.sv
interface gnpa_req_if
   import gnpa_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic              req_type;
   logic [SLOT_W-1:0] slot_to_free;

   modport source (output valid, output req_type, output slot_to_free, input ready);
   modport sink   (input valid, input req_type, input slot_to_free, output ready);
endinterface

>>> rtl/core/gnpa_rsp_if.sv
interface gnpa_rsp_if
   import gnpa_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [SLOT_W-1:0] slot_index;
   status_type        status;

   modport source (output valid, output slot_index, output status, input ready);
   modport sink   (input valid, input slot_index, input status, output ready);
endinterface

>>> rtl/core/growing_node_pool_allocator.sv
// An accepted item's result is in the output register in the cycle after its acceptance.
// A free, a fresh allocate or an exhausted allocate lets a new item be taken as soon
// as the result register drains; an allocate that pops the freed stack first holds
// off new items in ST_POP, as the new stack head comes from the registered link read.
// Reset (synchronous) empties the freed stack and opens a first segment of three
// slots; a csr_we write reinitialises the pool the same way with the written size.
module growing_node_pool_allocator
   import gnpa_pkg::*;
#(
   parameter int POOL_NODES = POOL_NODES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   gnpa_req_if.sink          req_ch,
   gnpa_rsp_if.source        rsp_ch,
   input  logic              csr_we,
   input  logic [CFG_W-1:0]  csr_wdata
);

   localparam int AW     = $clog2(POOL_NODES);
   localparam int IDX_W  = $clog2(POOL_NODES + 1);
   localparam int WIDE_W = (IDX_W + 2 > SLOT_W + 1) ? IDX_W + 2 : SLOT_W + 1;

   localparam logic [IDX_W-1:0]  EMPTY_HEAD = IDX_W'(POOL_NODES);
   localparam logic [WIDE_W-1:0] POOL_WIDE  = WIDE_W'(POOL_NODES);
   localparam logic [IDX_W-1:0]  RESET_SEG  = IDX_W'(INIT_SEGMENT_RESET);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_POP  = 2'b10
   } state_type;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [IDX_W-1:0]  fresh_ff, fresh_in;
   logic [IDX_W-1:0]  opened_ff, opened_in;
   logic [IDX_W-1:0]  seg_ff, seg_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   status_type        rsp_status_ff, rsp_status_in;

   // Link memory of the freed stack
   logic [IDX_W-1:0]  link_mem [POOL_NODES];
   logic [IDX_W-1:0]  link_rd_ff;
   logic              link_we;
   logic [AW-1:0]     link_waddr;

   logic              accept;
   logic [WIDE_W-1:0] slot_wide;
   logic [WIDE_W-1:0] cfg_wide;
   logic [IDX_W-1:0]  cfg_seg;
   logic [WIDE_W-1:0] grown_wide;
   logic [WIDE_W-1:0] grown_end;
   logic [WIDE_W-1:0] head_wide;
   logic [WIDE_W-1:0] fresh_wide;

   // Handshake: one item at a time, result register drains alongside;
   // hold off new items while the pool is being reinitialised
   assign req_ch.ready = !csr_we && (state_ff == ST_IDLE) &&
                         (!rsp_valid_ff || rsp_ch.ready);
   assign accept       = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.slot_index = rsp_slot_ff;
   assign rsp_ch.status     = rsp_status_ff;

   // Clamp the written first segment size into one to POOL_NODES
   assign cfg_wide = WIDE_W'(csr_wdata);
   always_comb begin
      if (cfg_wide == '0) begin
         cfg_seg = IDX_W'(1);
      end else if (cfg_wide > POOL_WIDE) begin
         cfg_seg = EMPTY_HEAD;
      end else begin
         cfg_seg = cfg_wide[IDX_W-1:0];
      end
   end

   assign slot_wide  = WIDE_W'(req_ch.slot_to_free);
   assign head_wide  = WIDE_W'(head_ff);
   assign fresh_wide = WIDE_W'(fresh_ff);
   assign grown_wide = WIDE_W'(seg_ff) << 1;
   assign grown_end  = WIDE_W'(opened_ff) + grown_wide;
   assign link_waddr = slot_wide[AW-1:0];

   // Next pool state and result
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      fresh_in      = fresh_ff;
      opened_in     = opened_ff;
      seg_in        = seg_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_status_in = rsp_status_ff;
      link_we       = 1'b0;

      // Drop a result once taken
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_we) begin
         state_in  = ST_IDLE;
         head_in   = EMPTY_HEAD;
         fresh_in  = '0;
         opened_in = cfg_seg;
         seg_in    = cfg_seg;
      end else if (state_ff == ST_POP) begin
         // Advance the stack head to the link read last cycle
         head_in  = link_rd_ff;
         state_in = ST_IDLE;
      end else if (accept) begin
         rsp_valid_in  = 1'b1;
         rsp_slot_in   = '0;
         rsp_status_in = STATUS_OK;
         if (req_ch.req_type == REQ_FREE) begin
            if (slot_wide >= WIDE_W'(opened_ff) || slot_wide >= POOL_WIDE) begin
               rsp_status_in = STATUS_OUTSIDE;
            end else begin
               link_we     = 1'b1;
               head_in     = slot_wide[IDX_W-1:0];
               rsp_slot_in = req_ch.slot_to_free;
            end
         end else if (head_ff != EMPTY_HEAD) begin
            rsp_slot_in = head_wide[SLOT_W-1:0];
            state_in    = ST_POP;
         end else if (fresh_ff < opened_ff) begin
            rsp_slot_in = fresh_wide[SLOT_W-1:0];
            fresh_in    = fresh_ff + IDX_W'(1);
         end else if (grown_end > POOL_WIDE) begin
            rsp_status_in = STATUS_EXHAUSTED;
         end else begin
            seg_in      = grown_wide[IDX_W-1:0];
            opened_in   = grown_end[IDX_W-1:0];
            rsp_slot_in = fresh_wide[SLOT_W-1:0];
            fresh_in    = fresh_ff + IDX_W'(1);
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= EMPTY_HEAD;
         fresh_ff     <= '0;
         opened_ff    <= RESET_SEG;
         seg_ff       <= RESET_SEG;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fresh_ff     <= fresh_in;
         opened_ff    <= opened_in;
         seg_ff       <= seg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      rsp_slot_ff   <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Link memory: push writes the old head, the head entry is read every cycle
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= head_ff;
      end
      link_rd_ff <= link_mem[head_ff[AW-1:0]];
   end

   // Checks
   a_pop_one_cycle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_POP |=> state_ff == ST_IDLE)
      else $error("pop wait lasted more than one cycle");

   a_pop_entered: assert property (@(posedge clock) disable iff (reset)
      accept && !csr_we && req_ch.req_type == REQ_ALLOC && head_ff != EMPTY_HEAD
      |=> state_ff == ST_POP)
      else $error("stack pop did not wait for the link read");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != STATUS_OK |-> rsp_slot_ff == '0)
      else $error("failed result carries a slot");

   a_fresh_in_region: assert property (@(posedge clock) disable iff (reset)
      fresh_ff <= opened_ff)
      else $error("fresh slot beyond opened region");

   a_region_fits: assert property (@(posedge clock) disable iff (reset)
      WIDE_W'(opened_ff) <= POOL_WIDE && head_wide <= POOL_WIDE)
      else $error("opened region or stack head beyond pool");

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import gnpa_pkg::*;

   localparam int POOL_SLOTS    = POOL_NODES_DEFAULT;
   localparam int SETTLE_CYCLES = 4;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int PHASES        = 7;

   // Idling per mode: none, sender idle, receiver stalling, both
   localparam int IDLE_PCT  [4] = '{0, 78, 0, 6};
   localparam int STALL_PCT [4] = '{0, 0, 78, 6};

   // Random phases: segment size, items, mix of requests, idling mode.
   // The third phase opens a large first segment that cannot grow, so the pool runs dry.
   localparam int PHASE_CFG       [PHASES] = '{0, 1023, 342, 512, 0, 0, 1};
   localparam int PHASE_ITEMS     [PHASES] = '{150, 150, 450, 200, 250, 150, 100};
   localparam int PHASE_ALLOC_PCT [PHASES] = '{60, 55, 88, 60, 60, 50, 65};
   localparam int PHASE_NOISE_PCT [PHASES] = '{10, 15, 6, 10, 10, 15, 10};
   localparam bit PHASE_STRAY     [PHASES] = '{1, 1, 0, 1, 1, 1, 1};
   localparam int PHASE_MODE      [PHASES] = '{0, 1, 2, 3, 0, 1, 2};

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      status_type        status;
   } pool_answer_type;

   typedef struct packed {
      logic              kind;
      logic [SLOT_W-1:0] slot;
      logic              fixed;
      pool_answer_type   want;
   } probe_row_type;

   // Opening sequence on the reset pool of three slots
   localparam probe_row_type PROBE_ROWS [24] = '{
      '{REQ_FREE,  10'd1023, 1'b1, '{10'd0, STATUS_OUTSIDE}},
      '{REQ_FREE,  10'd3,    1'b1, '{10'd0, STATUS_OUTSIDE}},
      '{REQ_ALLOC, 10'd0,    1'b1, '{10'd0, STATUS_OK}},
      '{REQ_ALLOC, 10'd0,    1'b0, '{10'd0, STATUS_OK}},
      '{REQ_ALLOC, 10'd1023, 1'b0, '{10'd0, STATUS_OK}},
      '{REQ_ALLOC, 10'd0,    1'b0, '{10'd0, STATUS_OK}},
      '{REQ_FREE,  10'd9,    1'b1, '{10'd0, STATUS_OUTSIDE}},
      '{REQ_FREE,  10'd8,    1'b0, '{10'd0, STATUS_OK}},
      '{REQ_FREE,  10'd0,    1'b0, '{10'd0, STATUS_OK}},
      '{REQ_ALLOC, 10'd0,    1'b0, '{10'd0, STATUS_OK}},
      '{REQ_ALLOC, 10'd0,    1'b0, '{10'd0, STATUS_OK}},
      '{REQ_ALLOC, 10'd0,    1'b0, '{10'd0, STATUS_OK}},
      '{REQ_FREE,  10'd512,  1'b1, '{10'd0, STATUS_OUTSIDE}},
      '{REQ_ALLOC, 10'd0,    1'b0, '{10'd0, STATUS_OK}},
      '{REQ_ALLOC, 10'd0,    1'b0, '{10'd0, STATUS_OK}},
      '{REQ_ALLOC, 10'd0,    1'b0, '{10'd0, STATUS_OK}},
      '{REQ_ALLOC, 10'd0,    1'b0, '{10'd0, STATUS_OK}},
      '{REQ_ALLOC, 10'd0,    1'b0, '{10'd0, STATUS_OK}},
      '{REQ_FREE,  10'd1,    1'b0, '{10'd0, STATUS_OK}},
      '{REQ_FREE,  10'd1,    1'b0, '{10'd0, STATUS_OK}},
      '{REQ_ALLOC, 10'd0,    1'b0, '{10'd0, STATUS_OK}},
      '{REQ_ALLOC, 10'd0,    1'b0, '{10'd0, STATUS_OK}},
      '{REQ_FREE,  10'd682,  1'b1, '{10'd0, STATUS_OUTSIDE}},
      '{REQ_FREE,  10'd341,  1'b1, '{10'd0, STATUS_OUTSIDE}}
   };

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               csr_we    = 1'b0;
   logic [CFG_W-1:0]   csr_wdata = '0;

   gnpa_req_if req_if ();
   gnpa_rsp_if rsp_if ();

   growing_node_pool_allocator u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Shadow of the pool
   logic [10:0]        link_mem [POOL_SLOTS];
   logic [10:0]        stack_top;
   logic [10:0]        fresh_slot;
   logic [10:0]        region_end;
   logic [10:0]        seg_len;

   pool_answer_type    answers_due [$];
   logic [SLOT_W-1:0]  held_slots [$];
   int                 error_count        = 0;
   int                 sender_idle_pct    = 0;
   int                 receiver_stall_pct = 0;
   int unsigned        cycle_count        = 0;

   always #1 clock = ~clock;

   // Empty the freed stack and open the first segment
   function automatic void pool_restart(input logic [CFG_W-1:0] size);
      logic [10:0] first;
      first      = (size == '0) ? 11'd1 : {1'b0, size};
      stack_top  = 11'(POOL_SLOTS);
      fresh_slot = '0;
      region_end = first;
      seg_len    = first;
   endfunction

   // Serve one request against the shadow pool
   function automatic pool_answer_type pool_serve(input logic kind,
                                                  input logic [SLOT_W-1:0] slot);
      pool_answer_type answer;
      logic [11:0]     grown;
      answer.slot   = '0;
      answer.status = STATUS_OK;
      if (kind == REQ_FREE) begin
         if ({1'b0, slot} >= region_end) begin
            answer.status = STATUS_OUTSIDE;
         end else begin
            link_mem[slot] = stack_top;
            stack_top      = {1'b0, slot};
            answer.slot    = slot;
         end
      end else if (stack_top < 11'(POOL_SLOTS)) begin
         answer.slot = stack_top[SLOT_W-1:0];
         stack_top   = link_mem[stack_top[SLOT_W-1:0]];
      end else if (fresh_slot < region_end) begin
         answer.slot = fresh_slot[SLOT_W-1:0];
         fresh_slot  = fresh_slot + 11'd1;
      end else begin
         grown = {seg_len, 1'b0};
         if ({1'b0, region_end} + grown > 12'(POOL_SLOTS)) begin
            answer.status = STATUS_EXHAUSTED;
         end else begin
            seg_len     = grown[10:0];
            region_end  = region_end + grown[10:0];
            answer.slot = fresh_slot[SLOT_W-1:0];
            fresh_slot  = fresh_slot + 11'd1;
         end
      end
      return answer;
   endfunction

   // Offer one item, hold it until taken, then log what it should return
   task automatic send_item(input logic kind, input logic [SLOT_W-1:0] slot,
                            input logic fixed, input pool_answer_type typed_answer);
      pool_answer_type served;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.req_type     <= kind;
      req_if.slot_to_free <= slot;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      served = pool_serve(kind, slot);
      answers_due.push_back(fixed ? typed_answer : served);
      if (kind == REQ_ALLOC && served.status == STATUS_OK)
         held_slots.push_back(served.slot);
   endtask

   // Drop valid and wait for the pool to go quiet
   task automatic settle_pool();
      req_if.valid <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_segment_size(input logic [CFG_W-1:0] size);
      csr_we    <= 1'b1;
      csr_wdata <= size;
      @(posedge clock);
      csr_we    <= 1'b0;
      pool_restart(size);
      held_slots.delete();
   endtask

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Compare each taken result with the oldest one due
   always @(posedge clock) begin : check_results
      pool_answer_type due;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (answers_due.size() == 0) begin
            $display("%0t: unexpected item, slot_index %0d status %0d", $time,
                     rsp_if.slot_index, rsp_if.status);
            error_count++;
         end else begin
            due = answers_due.pop_front();
            if (rsp_if.slot_index !== due.slot) begin
               $display("%0t: slot_index mismatch, expected %0d, actual %0d", $time,
                        due.slot, rsp_if.slot_index);
               error_count++;
            end
            if (rsp_if.status !== due.status) begin
               $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                        due.status, rsp_if.status);
               error_count++;
            end
         end
      end
   end

   // Guard against a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int                p;
      int                n;
      int                pick;
      int                idx;
      logic [SLOT_W-1:0] slot;
      logic [CFG_W-1:0]  size;

      req_if.valid        <= 1'b0;
      req_if.req_type     <= REQ_ALLOC;
      req_if.slot_to_free <= '0;
      pool_restart(CFG_W'(INIT_SEGMENT_RESET));
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Walk the opening table on the reset pool
      foreach (PROBE_ROWS[i])
         send_item(PROBE_ROWS[i].kind, PROBE_ROWS[i].slot, PROBE_ROWS[i].fixed,
                   PROBE_ROWS[i].want);

      // Random phases, each on a freshly sized pool
      for (p = 0; p < PHASES; p++) begin
         settle_pool();
         case (p)
            4:       size = CFG_W'($urandom_range(64, 2));
            5:       size = CFG_W'($urandom_range(1023, 1));
            default: size = CFG_W'(PHASE_CFG[p]);
         endcase
         write_segment_size(size);
         sender_idle_pct    = IDLE_PCT[PHASE_MODE[p]];
         receiver_stall_pct = STALL_PCT[PHASE_MODE[p]];
         for (n = 0; n < PHASE_ITEMS[p]; n++) begin
            pick = $urandom_range(99);
            slot = SLOT_W'($urandom_range(1023));
            if (pick < PHASE_ALLOC_PCT[p]) begin
               send_item(REQ_ALLOC, slot, 1'b0, '0);
            end else if (pick < PHASE_ALLOC_PCT[p] + PHASE_NOISE_PCT[p]) begin
               // stray free: where PHASE_STRAY is clear, keep it outside the region where the stack must stay sane
               if (!PHASE_STRAY[p] && {1'b0, slot} < region_end)
                  slot = SLOT_W'($urandom_range(1023, region_end));
               send_item(REQ_FREE, slot, 1'b0, '0);
            end else if (held_slots.size() != 0) begin
               idx  = $urandom_range(held_slots.size() - 1);
               slot = held_slots[idx];
               held_slots.delete(idx);
               send_item(REQ_FREE, slot, 1'b0, '0);
            end else begin
               send_item(REQ_ALLOC, slot, 1'b0, '0);
            end
         end
      end

      settle_pool();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
